FILE: hw/rtl/dcc_pkg.sv
// Shared constants and types of the distinct color counter.
`default_nettype none

package dcc_pkg;

    localparam int COLOR_W         = 8;
    localparam int KEY_W           = 24;
    localparam int CNT_W           = 17;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 24;
    localparam int ROW_BITS        = 32;
    localparam int BIT_W           = $clog2(ROW_BITS);
    localparam int QUEUE_DEPTH     = 2;
    localparam int WINDOW_BITS_DEF = 65536;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 1'd1;

    typedef struct packed {
        logic             gray_mode;
        logic [KEY_W-1:0] window_base;
    } t_cfg;

    typedef struct packed {
        logic             is_clear;
        logic             in_win;
        logic [KEY_W-1:0] offset;
    } t_work;

endpackage

`default_nettype wire

FILE: hw/rtl/dcc_ifs.sv
// Handshake interfaces of the pixel, result and configuration channels.
`default_nettype none

interface dcc_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [dcc_pkg::COLOR_W-1:0] red;
    logic [dcc_pkg::COLOR_W-1:0] green;
    logic [dcc_pkg::COLOR_W-1:0] blue;
    logic [dcc_pkg::COLOR_W-1:0] gray;

    modport source (output valid, cmd, red, green, blue, gray, input ready);
    modport sink (input valid, cmd, red, green, blue, gray, output ready);
endinterface

interface dcc_res_if;
    logic                      valid;
    logic                      ready;
    logic [dcc_pkg::CNT_W-1:0] distinct_count;
    logic                      is_new;

    modport source (output valid, distinct_count, is_new, input ready);
    modport sink (input valid, distinct_count, is_new, output ready);
endinterface

interface dcc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dcc_pkg::CFG_IDX_W-1:0]  index;
    logic [dcc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dcc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/dcc_front.sv
// Front end: accepts pixel beats and classifies them against the key window.
`default_nettype none

module dcc_front #(
    parameter int WINDOW_BITS = dcc_pkg::WINDOW_BITS_DEF
) (
    input  wire dcc_pkg::t_cfg  i_cfg,
    dcc_pix_if.sink             i_pix,
    output logic                o_push_valid,
    input  wire logic           i_push_ready,
    output dcc_pkg::t_work      o_push_data
);

    localparam logic [dcc_pkg::KEY_W:0] WIN_LIMIT = (dcc_pkg::KEY_W + 1)'(WINDOW_BITS);

    logic [dcc_pkg::KEY_W-1:0] key;
    logic [dcc_pkg::KEY_W:0]   diff;

    always_comb begin
        if (i_cfg.gray_mode) begin
            key = dcc_pkg::KEY_W'(i_pix.gray);
        end else begin
            key = {i_pix.red, i_pix.green, i_pix.blue};
        end
        diff = {1'b0, key} - {1'b0, i_cfg.window_base};

        o_push_data.is_clear = (i_pix.cmd == dcc_pkg::CMD_CLEAR);
        o_push_data.offset   = diff[dcc_pkg::KEY_W-1:0];
        o_push_data.in_win   = !diff[dcc_pkg::KEY_W] &&
                               ({1'b0, diff[dcc_pkg::KEY_W-1:0]} < WIN_LIMIT);
    end

    assign o_push_valid = i_pix.valid;
    assign i_pix.ready  = i_push_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/dcc_queue.sv
// Short queue of classified work between the front and back ends.
`default_nettype none

module dcc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire dcc_pkg::t_work i_push_data,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output dcc_pkg::t_work      o_pop_data
);

    localparam int DEPTH = dcc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dcc_pkg::t_work   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dcc_back.sv
// Back end: bitmap read-modify-write, clearing sweep, count and result register.
`default_nettype none

module dcc_back #(
    parameter int WINDOW_BITS = dcc_pkg::WINDOW_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_work_valid,
    output logic                o_work_ready,
    input  wire dcc_pkg::t_work i_work,
    dcc_res_if.source           o_res
);

    localparam int ROWS  = (WINDOW_BITS + dcc_pkg::ROW_BITS - 1) / dcc_pkg::ROW_BITS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int BIT_W = dcc_pkg::BIT_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW
    } t_state;

    t_state                         r_state;
    logic [ROW_W-1:0]               r_row;
    logic [BIT_W-1:0]               r_bit;
    logic [dcc_pkg::CNT_W-1:0]      r_count;
    logic                           r_out_valid;
    logic [dcc_pkg::CNT_W-1:0]      r_out_count;
    logic                           r_out_new;

    logic                           out_free;
    logic                           take;
    logic                           out_load;
    logic                           hit_bit;
    logic [dcc_pkg::CNT_W-1:0]      count_inc;
    logic                           ram_we;
    logic [ROW_W-1:0]               ram_waddr;
    logic [dcc_pkg::ROW_BITS-1:0]   ram_wdata;
    logic                           ram_re;
    logic [ROW_W-1:0]               ram_raddr;
    logic [dcc_pkg::ROW_BITS-1:0]   ram_rdata;

    assign out_free     = !r_out_valid || o_res.ready;
    assign o_work_ready = (r_state == S_IDLE) && out_free;
    assign take         = i_work_valid && o_work_ready;
    assign out_load     = (take && (i_work.is_clear || !i_work.in_win)) || (r_state == S_RMW);
    assign hit_bit      = ram_rdata[r_bit];
    assign count_inc    = (r_count == dcc_pkg::CNT_MAX) ? r_count : r_count + 1'b1;
    assign ram_re       = take && !i_work.is_clear && i_work.in_win;
    assign ram_raddr    = i_work.offset[BIT_W +: ROW_W];
    assign ram_waddr    = r_row;

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_RMW: begin
                ram_we    = !hit_bit;
                ram_wdata = ram_rdata | (dcc_pkg::ROW_BITS'(1) << r_bit);
            end
            S_IDLE: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    dcc_ram #(
        .WIDTH (dcc_pkg::ROW_BITS),
        .DEPTH (ROWS)
    ) u_dcc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        r_row   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        if (i_work.is_clear) begin
                            r_count     <= '0;
                            r_out_count <= '0;
                            r_out_new   <= 1'b0;
                            r_row       <= '0;
                            r_state     <= S_CLEAR;
                        end else if (i_work.in_win) begin
                            r_row   <= ram_raddr;
                            r_bit   <= i_work.offset[BIT_W-1:0];
                            r_state <= S_RMW;
                        end else begin
                            r_out_count <= r_count;
                            r_out_new   <= 1'b0;
                        end
                    end
                end
                S_RMW: begin
                    if (!hit_bit) begin
                        r_count     <= count_inc;
                        r_out_count <= count_inc;
                        r_out_new   <= 1'b1;
                    end else begin
                        r_out_count <= r_count;
                        r_out_new   <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.distinct_count = r_out_count;
    assign o_res.is_new         = r_out_new;

endmodule

`default_nettype wire

FILE: hw/rtl/distinct_color_counter.sv
// Top level of the distinct color counter: configuration registers and block wiring.
// A pixel beat forms a color key (24-bit RGB, or the gray byte in gray mode), and keys
// inside [window_base, window_base + WINDOW_BITS - 1] are looked up in a seen-bitmap held
// in a RAM of 32-bit rows; a first sighting sets the bit and raises the count, which
// saturates at its 17-bit maximum. The front end classifies each beat and a two-entry
// queue decouples it from the back end, so pixels are taken while a result waits. In the
// back end an in-window pixel is a row read followed by its write-back through the single
// bitmap RAM, and an out-of-window pixel or a clear command needs no row read. Reset
// and every clear command start a sweep that zeroes the bitmap one row per cycle over
// ceil(WINDOW_BITS / 32) rows (2048 at the default window), during which no further
// work leaves the queue; configuration writes are taken at any time with ready held high.
`default_nettype none

module distinct_color_counter #(
    parameter int WINDOW_BITS = dcc_pkg::WINDOW_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dcc_cfg_if.sink   i_cfg,
    dcc_pix_if.sink   i_pix,
    dcc_res_if.source o_res
);

    dcc_pkg::t_cfg  r_cfg;
    logic           push_valid;
    logic           push_ready;
    dcc_pkg::t_work push_data;
    logic           work_valid;
    logic           work_ready;
    dcc_pkg::t_work work_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dcc_pkg::CFG_GRAY_MODE: begin
                    r_cfg.gray_mode <= i_cfg.data[0];
                end
                dcc_pkg::CFG_WINDOW_BASE: begin
                    r_cfg.window_base <= i_cfg.data[dcc_pkg::KEY_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    dcc_front #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dcc_front (
        .i_cfg        (r_cfg),
        .i_pix        (i_pix),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    dcc_queue u_dcc_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (work_valid),
        .i_pop_ready  (work_ready),
        .o_pop_data   (work_data)
    );

    dcc_back #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dcc_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .o_work_ready (work_ready),
        .i_work       (work_data),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/dcc_checker.sv
// Port-level assertions of the distinct color counter and their bind statement.
`default_nettype none

module dcc_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [dcc_pkg::CNT_W-1:0] i_distinct_count,
    input wire logic                      i_is_new
);

    logic                      in_acc;
    logic                      out_acc;
    logic [dcc_pkg::CNT_W-1:0] r_last;
    logic [2:0]                r_pend;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_pend <= '0;
        end else begin
            if (out_acc) begin
                r_last <= i_distinct_count;
            end
            if (in_acc && !out_acc) begin
                r_pend <= r_pend + 1'b1;
            end else if (out_acc && !in_acc) begin
                r_pend <= r_pend - 1'b1;
            end
        end
    end

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_distinct_count) && $stable(i_is_new))
        else $error("result beat changed while stalled");

    // Every result belongs to an accepted pixel or clear beat.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 3'd0)
        else $error("result without an outstanding beat");

    // A new key raises the count by one unless it is saturated.
    a_new_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && i_is_new |->
            (i_distinct_count == r_last + 1'b1) ||
            (i_distinct_count == dcc_pkg::CNT_MAX && r_last == dcc_pkg::CNT_MAX))
        else $error("count did not step on a new key");

    // Without a new key the count holds, or drops to zero on a clear.
    a_old_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !i_is_new |->
            (i_distinct_count == r_last) || (i_distinct_count == '0))
        else $error("count changed without a new key");

endmodule

bind distinct_color_counter dcc_checker u_dcc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_pix.valid),
    .i_in_ready       (i_pix.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_distinct_count (o_res.distinct_count),
    .i_is_new         (o_res.is_new)
);

`default_nettype wire
